// ----- rtl/mips_subset_execute_unit_defines.svh -----
// assertion macros for the mips subset execute unit
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with reset disabling
`define MSE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk with reset disabling
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mse_pkg.sv -----
// types, codes and helpers shared by the mips subset execute unit
package mse_pkg;

	localparam int REG_IDX_W = 5;
	localparam int WORD_W    = 32;
	localparam int PC_W      = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int NUM_BANKS = 4;
	localparam int NUM_PORTS = 2;

	typedef enum logic [4:0] {
		CMD_ADDI, CMD_SUBI, CMD_XORI, CMD_SLL, CMD_SRL, CMD_ADD, CMD_SUB, CMD_XOR,
		CMD_LW, CMD_SW, CMD_LB, CMD_SB, CMD_LA, CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGT,
		CMD_J, CMD_JR, CMD_JAL, CMD_SYSCALL
	} cmd_t;

	typedef enum logic [1:0] {
		FAULT_NONE,
		FAULT_MEM,
		FAULT_JUMP
	} fault_t;

	typedef enum logic [1:0] {
		WB_ALU,
		WB_WORD,
		WB_BYTE
	} wb_kind_t;

	localparam logic PRINT_INT  = 1'b0;
	localparam logic PRINT_CHAR = 1'b1;

	localparam logic [WORD_W-1:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [WORD_W-1:0] SYS_EXIT       = 32'd10;
	localparam logic [WORD_W-1:0] SYS_PRINT_CHAR = 32'd11;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMPS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RA_INDEX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SP_INDEX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_V0_INDEX       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_A0_INDEX       = 3'd5;

	localparam logic [CFG_W-1:0]     RST_MAX_JUMPS      = 16'd1000;
	localparam logic [CFG_W-1:0]     RST_PROGRAM_LENGTH = 16'd0;
	localparam logic [REG_IDX_W-1:0] RST_RA_INDEX       = 5'd17;
	localparam logic [REG_IDX_W-1:0] RST_SP_INDEX       = 5'd16;
	localparam logic [REG_IDX_W-1:0] RST_V0_INDEX       = 5'd1;
	localparam logic [REG_IDX_W-1:0] RST_A0_INDEX       = 5'd2;

	// big-endian byte i of a word, byte 0 being the most significant
	function automatic logic [7:0] word_byte(input logic [WORD_W-1:0] w, input logic [1:0] i);
		word_byte = w[{~i, 3'b000} +: 8];
	endfunction

endpackage

// ----- rtl/mips_subset_execute_unit.sv -----
// execute unit for a small mips-like instruction subset
// One decoded instruction enters per in_valid/in_ready transaction (cmd, dst_reg,
// src_a_reg, src_b_reg, imm_value); exactly one result leaves per out_valid/out_ready
// transaction (next_pc, fault, print_valid, print_kind, print_value, halted).
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data, one per
// cycle, only while no transaction is in flight; the user must keep to this, the
// block does not enforce it. A result is offered by stage 2 after passing stage 1.
// Throughput: one instruction per cycle while out_ready and the reset sweep allow,
// dependent ones included. The register file has two read ports read on acceptance;
// the data memory is four byte-wide banks read on the move to stage 2, so a word
// access touches each bank once. Register writes retire from the output stage and
// are forwarded to the instruction behind. Reset zeroes pc and jump counter, loads
// configuration defaults, marks every register entry as holding its reset value, then
// zeroes all ceil(MEM_BYTES/4) bank rows (64 at the default size) with in_ready low.
// When the receiver stalls, the output stage holds its result, one more instruction
// can still be taken into the first stage, then in_ready drops until out_ready.
`include "mips_subset_execute_unit_defines.svh"

module mips_subset_execute_unit
	import mse_pkg::*;
#(
	parameter int MEM_BYTES = 256,
	parameter int NUM_REGS  = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [4:0]           cmd,
	input  logic [4:0]           dst_reg,
	input  logic [4:0]           src_a_reg,
	input  logic [4:0]           src_b_reg,
	input  logic signed [31:0]   imm_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          next_pc,
	output logic [1:0]           fault,
	output logic                 print_valid,
	output logic                 print_kind,
	output logic signed [31:0]   print_value,
	output logic                 halted,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int RW         = $clog2(NUM_REGS);
	localparam int BANK_DEPTH = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
	localparam int BW         = $clog2(BANK_DEPTH);
	localparam logic [REG_IDX_W:0]  REG_LIMIT      = (REG_IDX_W + 1)'(NUM_REGS);
	localparam logic [WORD_W-1:0]   SP_RESET_VALUE = WORD_W'(MEM_BYTES - 1);
	localparam logic [WORD_W-1:0]   LAST_WORD_ADDR = WORD_W'(MEM_BYTES - 4);
	localparam logic [WORD_W-1:0]   LAST_BYTE_ADDR = WORD_W'(MEM_BYTES - 1);
	localparam logic [BW-1:0]       LAST_ROW       = BW'(BANK_DEPTH - 1);

	// configuration
	logic [CFG_W-1:0]     max_jumps_q;
	logic [CFG_W-1:0]     program_length_q;
	logic [REG_IDX_W-1:0] ra_index_q;
	logic [REG_IDX_W-1:0] v0_index_q;
	logic [REG_IDX_W-1:0] a0_index_q;

	// architectural control state
	logic [PC_W-1:0]     pc_q;
	logic [CFG_W-1:0]    jcnt_q;
	logic [NUM_REGS-1:0] rvalid_q;
	logic                clr_busy_q;
	logic [BW-1:0]       clr_row_q;

	// handshake
	logic adv1, adv2, in_fire, mv1, wb_fire;

	// register file
	logic [WORD_W-1:0] rf_mem [NUM_REGS];
	logic [REG_IDX_W-1:0] ridx_c [NUM_PORTS];
	cmd_t in_cmd_c;

	// stage 1
	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic [REG_IDX_W-1:0] dst_s1;
	logic [WORD_W-1:0]    imm_s1;
	logic [REG_IDX_W-1:0] ridx_s1  [NUM_PORTS];
	logic                 rinr_s1  [NUM_PORTS];
	logic                 rbyp_s1  [NUM_PORTS];
	logic                 rvld_s1  [NUM_PORTS];
	logic                 rsp_s1   [NUM_PORTS];
	logic [WORD_W-1:0]    rbdat_s1 [NUM_PORTS];
	logic [WORD_W-1:0]    rmem_s1  [NUM_PORTS];
	logic [WORD_W-1:0]    op_c     [NUM_PORTS];

	logic [WORD_W-1:0]    addr_c;
	logic [PC_W-1:0]      pc_inc_c;
	logic [1:0]           ofs_c;
	logic [BW-1:0]        row0_c;
	logic                 is_branch_c;
	logic [PC_W-1:0]      npc_c;
	fault_t               fault_c;
	logic                 pv_c, pk_c, halt_c;
	logic [WORD_W-1:0]    pval_c;
	logic                 wen_c, wen_ok_c;
	logic [REG_IDX_W-1:0] widx_c;
	logic [WORD_W-1:0]    wdata_c;
	wb_kind_t             wkind_c;
	logic                 st_en_c, st_word_c, jinc_c;

	// data memory banks
	logic [NUM_BANKS-1:0] bank_we;
	logic [BW-1:0]        bank_waddr [NUM_BANKS];
	logic [7:0]           bank_wdata [NUM_BANKS];
	logic [BW-1:0]        brow_c     [NUM_BANKS];
	logic [7:0]           brd_s2     [NUM_BANKS];

	// stage 2, also the output register
	logic              valid_s2;
	logic              wen_s2;
	logic [RW-1:0]     widx_s2;
	wb_kind_t          wkind_s2;
	logic [WORD_W-1:0] wdata_s2;
	logic [1:0]        ofs_s2;
	logic [PC_W-1:0]   next_pc_s2;
	fault_t            fault_s2;
	logic              print_valid_s2, print_kind_s2, halted_s2;
	logic [WORD_W-1:0] print_value_s2;
	logic [WORD_W-1:0] ld_word_c, wb_data_c;

	assign adv2     = !valid_s2 || out_ready;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1 && !clr_busy_q;
	assign in_fire  = in_valid && in_ready;
	assign mv1      = valid_s1 && adv2;
	assign wb_fire  = valid_s2 && out_ready && wen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_jumps_q      <= RST_MAX_JUMPS;
			program_length_q <= RST_PROGRAM_LENGTH;
			ra_index_q       <= RST_RA_INDEX;
			v0_index_q       <= RST_V0_INDEX;
			a0_index_q       <= RST_A0_INDEX;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MAX_JUMPS:      max_jumps_q      <= cfg_data;
				CFG_PROGRAM_LENGTH: program_length_q <= cfg_data;
				CFG_RA_INDEX:       ra_index_q       <= cfg_data[REG_IDX_W-1:0];
				// the stack pointer only matters at reset
				CFG_SP_INDEX:       ;
				CFG_V0_INDEX:       v0_index_q       <= cfg_data[REG_IDX_W-1:0];
				CFG_A0_INDEX:       a0_index_q       <= cfg_data[REG_IDX_W-1:0];
				default:            ;
			endcase
		end
	end

	// read port addresses: syscall reads v0/a0, stores and lb read the dst register
	always_comb begin
		in_cmd_c  = cmd_t'(cmd);
		ridx_c[0] = (in_cmd_c == CMD_SYSCALL) ? v0_index_q : src_a_reg;
		if (in_cmd_c == CMD_SYSCALL) begin
			ridx_c[1] = a0_index_q;
		end else if (in_cmd_c == CMD_SW || in_cmd_c == CMD_LB || in_cmd_c == CMD_SB) begin
			ridx_c[1] = dst_reg;
		end else begin
			ridx_c[1] = src_b_reg;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			rf_mem[widx_s2] <= wb_data_c;
		end
		if (in_fire) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				rmem_s1[p] <= rf_mem[ridx_c[p][RW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (wb_fire) begin
			rvalid_q[widx_s2] <= 1'b1;
		end
	end

	// stage 1 payload and read-port side information
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= in_cmd_c;
			dst_s1 <= dst_reg;
			imm_s1 <= imm_value;
			for (int p = 0; p < NUM_PORTS; p++) begin
				ridx_s1[p]  <= ridx_c[p];
				rinr_s1[p]  <= ({1'b0, ridx_c[p]} < REG_LIMIT);
				rbyp_s1[p]  <= wb_fire && ({1'b0, ridx_c[p]} < REG_LIMIT) &&
					(ridx_c[p][RW-1:0] == widx_s2);
				rbdat_s1[p] <= wb_data_c;
				rvld_s1[p]  <= rvalid_q[ridx_c[p][RW-1:0]];
				rsp_s1[p]   <= (ridx_c[p] == RST_SP_INDEX);
			end
		end
	end

	// operands with forwarding from the output stage
	always_comb begin
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (!rinr_s1[p]) begin
				op_c[p] = '0;
			end else if (valid_s2 && wen_s2 && ridx_s1[p][RW-1:0] == widx_s2) begin
				op_c[p] = wb_data_c;
			end else if (rbyp_s1[p]) begin
				op_c[p] = rbdat_s1[p];
			end else if (rvld_s1[p]) begin
				op_c[p] = rmem_s1[p];
			end else begin
				op_c[p] = rsp_s1[p] ? SP_RESET_VALUE : '0;
			end
		end
	end

	always_comb begin
		addr_c      = op_c[0] + imm_s1;
		pc_inc_c    = pc_q + 16'd1;
		ofs_c       = addr_c[1:0];
		row0_c      = addr_c[BW+1:2];
		is_branch_c = (cmd_s1 >= CMD_BEQ) && (cmd_s1 <= CMD_JAL);
		npc_c       = pc_inc_c;
		fault_c     = FAULT_NONE;
		pv_c        = 1'b0;
		pk_c        = PRINT_INT;
		pval_c      = '0;
		halt_c      = 1'b0;
		wen_c       = 1'b0;
		widx_c      = dst_s1;
		wdata_c     = '0;
		wkind_c     = WB_ALU;
		st_en_c     = 1'b0;
		st_word_c   = 1'b0;
		jinc_c      = 1'b0;
		if (is_branch_c) begin
			if (jcnt_q >= max_jumps_q) begin
				fault_c = FAULT_JUMP;
			end else begin
				jinc_c = 1'b1;
				unique case (cmd_s1)
					CMD_BEQ: if (op_c[0] == op_c[1]) npc_c = imm_s1[PC_W-1:0];
					CMD_BNE: if (op_c[0] != op_c[1]) npc_c = imm_s1[PC_W-1:0];
					CMD_BLT: if ($signed(op_c[0]) < $signed(op_c[1])) npc_c = imm_s1[PC_W-1:0];
					CMD_BGT: if ($signed(op_c[1]) < $signed(op_c[0])) npc_c = imm_s1[PC_W-1:0];
					CMD_J:   npc_c = imm_s1[PC_W-1:0];
					CMD_JR:  npc_c = op_c[0][PC_W-1:0];
					CMD_JAL: begin
						wen_c   = 1'b1;
						widx_c  = ra_index_q;
						wdata_c = {{(WORD_W-PC_W){1'b0}}, pc_inc_c};
						npc_c   = imm_s1[PC_W-1:0];
					end
					default: ;
				endcase
			end
		end else begin
			unique case (cmd_s1)
				CMD_ADDI: begin wen_c = 1'b1; wdata_c = op_c[0] + imm_s1; end
				CMD_SUBI: begin wen_c = 1'b1; wdata_c = op_c[0] - imm_s1; end
				CMD_XORI: begin wen_c = 1'b1; wdata_c = op_c[0] ^ imm_s1; end
				CMD_SLL:  begin wen_c = 1'b1; wdata_c = op_c[0] << imm_s1[4:0]; end
				CMD_SRL:  begin wen_c = 1'b1; wdata_c = op_c[0] >> imm_s1[4:0]; end
				CMD_ADD:  begin wen_c = 1'b1; wdata_c = op_c[0] + op_c[1]; end
				CMD_SUB:  begin wen_c = 1'b1; wdata_c = op_c[0] - op_c[1]; end
				CMD_XOR:  begin wen_c = 1'b1; wdata_c = op_c[0] ^ op_c[1]; end
				CMD_LW: begin
					if (addr_c <= LAST_WORD_ADDR) begin
						wen_c   = 1'b1;
						wkind_c = WB_WORD;
					end else begin
						fault_c = FAULT_MEM;
					end
				end
				CMD_SW: begin
					if (addr_c <= LAST_WORD_ADDR) begin
						st_en_c   = 1'b1;
						st_word_c = 1'b1;
					end else begin
						fault_c = FAULT_MEM;
					end
				end
				CMD_LB: begin
					if (addr_c <= LAST_BYTE_ADDR) begin
						wen_c   = 1'b1;
						wkind_c = WB_BYTE;
						wdata_c = op_c[1];
					end else begin
						fault_c = FAULT_MEM;
					end
				end
				CMD_SB: begin
					if (addr_c <= LAST_BYTE_ADDR) begin
						st_en_c = 1'b1;
					end else begin
						fault_c = FAULT_MEM;
					end
				end
				CMD_LA: begin wen_c = 1'b1; wdata_c = imm_s1; end
				CMD_SYSCALL: begin
					priority if (op_c[0] == SYS_PRINT_INT) begin
						pv_c   = 1'b1;
						pk_c   = PRINT_INT;
						pval_c = op_c[1];
					end else if (op_c[0] == SYS_PRINT_CHAR) begin
						if (op_c[1][7:0] != 8'h00) begin
							pv_c   = 1'b1;
							pk_c   = PRINT_CHAR;
							pval_c = {{(WORD_W-8){1'b0}}, op_c[1][7:0]};
						end
					end else if (op_c[0] == SYS_EXIT) begin
						npc_c  = program_length_q;
						halt_c = 1'b1;
					end else begin
						pv_c = 1'b0;
					end
				end
				default: ;
			endcase
		end
		wen_ok_c = wen_c && ({1'b0, widx_c} < REG_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pc_q       <= '0;
			jcnt_q     <= '0;
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_fire;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (mv1) begin
				pc_q <= npc_c;
				if (jinc_c) begin
					jcnt_q <= jcnt_q + 16'd1;
				end
			end
			if (clr_busy_q) begin
				if (clr_row_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_row_q <= clr_row_q + BW'(1);
				end
			end
		end
	end

	// bank k holds bytes whose address is k modulo four
	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			brow_c[k] = (2'(k) >= ofs_c) ? row0_c : row0_c + BW'(1);
			if (clr_busy_q) begin
				bank_we[k]    = 1'b1;
				bank_waddr[k] = clr_row_q;
				bank_wdata[k] = 8'h00;
			end else begin
				bank_we[k]    = mv1 && st_en_c && (st_word_c || 2'(k) == ofs_c);
				bank_waddr[k] = brow_c[k];
				bank_wdata[k] = st_word_c ? word_byte(op_c[1], 2'(k) - ofs_c) : op_c[1][7:0];
			end
		end
	end

	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		logic [7:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (bank_we[k]) begin
				mem[bank_waddr[k]] <= bank_wdata[k];
			end
			if (mv1) begin
				brd_s2[k] <= mem[brow_c[k]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			wen_s2         <= wen_ok_c;
			widx_s2        <= widx_c[RW-1:0];
			wkind_s2       <= wkind_c;
			wdata_s2       <= wdata_c;
			ofs_s2         <= ofs_c;
			next_pc_s2     <= npc_c;
			fault_s2       <= fault_c;
			print_valid_s2 <= pv_c;
			print_kind_s2  <= pk_c;
			print_value_s2 <= pval_c;
			halted_s2      <= halt_c;
		end
	end

	// load data assembly and write-back value
	always_comb begin
		for (int i = 0; i < NUM_BANKS; i++) begin
			ld_word_c[8*(NUM_BANKS-1-i) +: 8] = brd_s2[ofs_s2 + 2'(i)];
		end
		unique case (wkind_s2)
			WB_WORD: wb_data_c = ld_word_c;
			WB_BYTE: wb_data_c = {wdata_s2[WORD_W-1:8], brd_s2[ofs_s2]};
			default: wb_data_c = wdata_s2;
		endcase
	end

	assign out_valid   = valid_s2;
	assign next_pc     = next_pc_s2;
	assign fault       = fault_s2;
	assign print_valid = print_valid_s2;
	assign print_kind  = print_kind_s2;
	assign print_value = $signed(print_value_s2);
	assign halted      = halted_s2;

	`MSE_ASSERT_SAME(a_no_store_on_fault, valid_s1 && (fault_c == FAULT_MEM), !(|bank_we), "memory written despite an address fault")
	`MSE_ASSERT_SAME(a_wb_in_range, wb_fire, ({1'b0, {(REG_IDX_W-RW){1'b0}}, widx_s2} < REG_LIMIT), "register write outside the file")
	`MSE_ASSERT_SAME(a_halt_pc, valid_s2 && halted_s2, next_pc_s2 == program_length_q, "halt without pc at program end")
	`MSE_ASSERT_NEXT(a_jump_step, 1'b1, (jcnt_q == $past(jcnt_q)) || (jcnt_q == $past(jcnt_q) + 16'd1), "jump counter moved by more than one")

endmodule

// ----- sim/testbench.sv -----
// testbench for the mips subset execute unit: directed table, then random program fragments
`timescale 1ns / 100ps

module testbench;
	import mse_pkg::*;

	localparam int unsigned MEM_BYTES = 256;
	localparam int unsigned NUM_REGS  = 18;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 150;

	typedef struct packed {
		logic [4:0]  op;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [31:0] imm;
	} instr_t;

	typedef struct packed {
		logic [15:0] pc;
		logic [1:0]  flt;
		logic        pv;
		logic        pk;
		logic [31:0] pval;
		logic        halt;
	} result_t;

	typedef struct {
		instr_t  ins;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [4:0]           cmd;
	logic [4:0]           dst_reg;
	logic [4:0]           src_a_reg;
	logic [4:0]           src_b_reg;
	logic signed [31:0]   imm_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [15:0]          next_pc;
	logic [1:0]           fault;
	logic                 print_valid;
	logic                 print_kind;
	logic signed [31:0]   print_value;
	logic                 halted;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// architectural copy of the unit
	logic [31:0] arch_regs [NUM_REGS];
	logic [7:0]  arch_mem [MEM_BYTES];
	logic [15:0] arch_pc;
	logic [15:0] arch_jumps;
	logic [15:0] cap_jumps;
	logic [15:0] prog_len;
	logic [4:0]  ra_sel;
	logic [4:0]  sp_sel;
	logic [4:0]  v0_sel;
	logic [4:0]  a0_sel;

	result_t outcomes [$];
	int sent_count = 0;
	int retired_count = 0;
	int mismatch_count = 0;
	int n_prints = 0;
	int n_halts = 0;
	int n_mem_faults = 0;
	int n_jump_faults = 0;
	bit steady_run = 1'b0;

	dir_row_t directed_rows [28] = '{
		'{'{CMD_LW,  5'd3,  5'd16, 5'd0,  32'h0000_0000}, 1'b1,
			'{16'd1, FAULT_MEM, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_SW,  5'd16, 5'd16, 5'd0,  32'hFFFF_FFFD}, 1'b1,
			'{16'd2, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_LB,  5'd3,  5'd16, 5'd0,  32'h0000_0000}, 1'b1,
			'{16'd3, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_SB,  5'd16, 5'd16, 5'd0,  32'h0000_0001}, 1'b1,
			'{16'd4, FAULT_MEM, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_LA,  5'd4,  5'd0,  5'd0,  32'h7FFF_FFFF}, 1'b1,
			'{16'd5, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_LA,  5'd5,  5'd0,  5'd0,  32'h8000_0000}, 1'b1,
			'{16'd6, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_ADDI, 5'd6,  5'd4,  5'd0,  32'h0000_0001}, 1'b0, '0},
		'{'{CMD_SUBI, 5'd31, 5'd5,  5'd0,  32'h0000_0001}, 1'b0, '0},
		'{'{CMD_XORI, 5'd8,  5'd4,  5'd0,  32'hFFFF_FFFF}, 1'b0, '0},
		'{'{CMD_SLL,  5'd9,  5'd4,  5'd0,  32'h0000_0021}, 1'b0, '0},
		'{'{CMD_SRL,  5'd10, 5'd5,  5'd0,  32'hFFFF_FFFF}, 1'b0, '0},
		'{'{CMD_ADD,  5'd11, 5'd4,  5'd4,  32'h0000_0000}, 1'b0, '0},
		'{'{CMD_SUB,  5'd12, 5'd5,  5'd31, 32'h0000_0000}, 1'b0, '0},
		'{'{CMD_XOR,  5'd13, 5'd5,  5'd4,  32'h0000_0000}, 1'b0, '0},
		'{'{CMD_SB,   5'd4,  5'd16, 5'd0,  32'hFFFF_FF01}, 1'b0, '0},
		'{'{CMD_LW,   5'd14, 5'd0,  5'd0,  32'h0000_0000}, 1'b0, '0},
		'{'{CMD_LA,   5'd1,  5'd0,  5'd0,  SYS_PRINT_INT}, 1'b0, '0},
		'{'{CMD_LA,   5'd2,  5'd0,  5'd0,  32'h8000_0000}, 1'b0, '0},
		'{'{CMD_SYSCALL, 5'd0, 5'd0, 5'd0, 32'h0000_0000}, 1'b1,
			'{16'd19, FAULT_NONE, 1'b1, PRINT_INT, 32'h8000_0000, 1'b0}},
		'{'{CMD_BEQ,  5'd0,  5'd4,  5'd4,  32'h0000_FFFF}, 1'b0, '0},
		'{'{CMD_LA,   5'd1,  5'd0,  5'd0,  SYS_EXIT}, 1'b1,
			'{16'd0, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b0}},
		'{'{CMD_BNE,  5'd0,  5'd4,  5'd5,  32'h0000_0003}, 1'b0, '0},
		'{'{CMD_BLT,  5'd0,  5'd5,  5'd4,  32'h0000_0064}, 1'b0, '0},
		'{'{CMD_BGT,  5'd0,  5'd5,  5'd4,  32'h0000_00C8}, 1'b0, '0},
		'{'{CMD_J,    5'd0,  5'd0,  5'd0,  32'h0000_8000}, 1'b0, '0},
		'{'{CMD_JAL,  5'd0,  5'd0,  5'd0,  32'h0000_1234}, 1'b0, '0},
		'{'{CMD_JR,   5'd0,  5'd17, 5'd0,  32'h0000_0000}, 1'b0, '0},
		'{'{CMD_SYSCALL, 5'd0, 5'd0, 5'd0, 32'h0000_0000}, 1'b1,
			'{16'd0, FAULT_NONE, 1'b0, PRINT_INT, 32'd0, 1'b1}}
	};

	mips_subset_execute_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] arch_read(input logic [4:0] idx);
		return (idx < NUM_REGS) ? arch_regs[idx] : 32'd0;
	endfunction

	function automatic void arch_write(input logic [4:0] idx, input logic [31:0] v);
		if (idx < NUM_REGS) begin
			arch_regs[idx] = v;
		end
	endfunction

	function automatic bit fits(input logic [31:0] a, input int unsigned n);
		return (a < MEM_BYTES) && ((MEM_BYTES - a) >= n);
	endfunction

	function automatic int draw_gap();
		if (steady_run) begin
			return 0;
		end
		return ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(16, 0);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7, 0))
		0: begin
			return 32'h8000_0000;
		end
		1: begin
			return 32'h7FFF_FFFF;
		end
		2: begin
			return 32'hFFFF_FFFF;
		end
		3: begin
			return 32'd0;
		end
		4: begin
			return $urandom_range(40, 0);
		end
		default: begin
			return $urandom;
		end
		endcase
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(9, 0) == 0) ? 5'($urandom_range(31, 18)) : 5'($urandom_range(17, 0));
	endfunction

	function automatic instr_t mk(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] ra,
			input logic [4:0] rb, input logic [31:0] imm);
		instr_t i;
		i.op = op;
		i.rd = rd;
		i.ra = ra;
		i.rb = rb;
		i.imm = imm;
		return i;
	endfunction

	function automatic void reset_arch();
		foreach (arch_regs[i]) begin
			arch_regs[i] = 32'd0;
		end
		foreach (arch_mem[i]) begin
			arch_mem[i] = 8'd0;
		end
		arch_pc = 16'd0;
		arch_jumps = 16'd0;
		cap_jumps = RST_MAX_JUMPS;
		prog_len = RST_PROGRAM_LENGTH;
		ra_sel = RST_RA_INDEX;
		sp_sel = RST_SP_INDEX;
		v0_sel = RST_V0_INDEX;
		a0_sel = RST_A0_INDEX;
		arch_write(sp_sel, MEM_BYTES - 1);
	endfunction

	task automatic run_instruction(input instr_t ins, output result_t res);
		logic [31:0] va;
		logic [31:0] vb;
		logic [31:0] v;
		logic [31:0] addr;
		logic [31:0] code;
		logic [31:0] arg;
		logic [15:0] target;
		va = arch_read(ins.ra);
		vb = arch_read(ins.rb);
		v = arch_read(ins.rd);
		addr = va + ins.imm;
		target = ins.imm[15:0];
		res = '0;
		arch_pc = arch_pc + 16'd1;
		if (ins.op >= CMD_BEQ && ins.op <= CMD_JAL) begin
			if (arch_jumps >= cap_jumps) begin
				res.flt = FAULT_JUMP;
			end else begin
				arch_jumps = arch_jumps + 16'd1;
				case (ins.op)
				CMD_BEQ: begin
					if (va == vb) arch_pc = target;
				end
				CMD_BNE: begin
					if (va != vb) arch_pc = target;
				end
				CMD_BLT: begin
					if ($signed(va) < $signed(vb)) arch_pc = target;
				end
				CMD_BGT: begin
					if ($signed(vb) < $signed(va)) arch_pc = target;
				end
				CMD_J: begin
					arch_pc = target;
				end
				CMD_JR: begin
					arch_pc = va[15:0];
				end
				default: begin
					arch_write(ra_sel, {16'd0, arch_pc});
					arch_pc = target;
				end
				endcase
			end
		end else begin
			case (ins.op)
			CMD_ADDI: begin
				arch_write(ins.rd, va + ins.imm);
			end
			CMD_SUBI: begin
				arch_write(ins.rd, va - ins.imm);
			end
			CMD_XORI: begin
				arch_write(ins.rd, va ^ ins.imm);
			end
			CMD_SLL: begin
				arch_write(ins.rd, va << ins.imm[4:0]);
			end
			CMD_SRL: begin
				arch_write(ins.rd, va >> ins.imm[4:0]);
			end
			CMD_ADD: begin
				arch_write(ins.rd, va + vb);
			end
			CMD_SUB: begin
				arch_write(ins.rd, va - vb);
			end
			CMD_XOR: begin
				arch_write(ins.rd, va ^ vb);
			end
			CMD_LW: begin
				if (!fits(addr, 4)) begin
					res.flt = FAULT_MEM;
				end else begin
					arch_write(ins.rd, {arch_mem[addr[7:0]], arch_mem[addr[7:0] + 8'd1],
						arch_mem[addr[7:0] + 8'd2], arch_mem[addr[7:0] + 8'd3]});
				end
			end
			CMD_SW: begin
				if (!fits(addr, 4)) begin
					res.flt = FAULT_MEM;
				end else begin
					arch_mem[addr[7:0]] = v[31:24];
					arch_mem[addr[7:0] + 8'd1] = v[23:16];
					arch_mem[addr[7:0] + 8'd2] = v[15:8];
					arch_mem[addr[7:0] + 8'd3] = v[7:0];
				end
			end
			CMD_LB: begin
				if (!fits(addr, 1)) begin
					res.flt = FAULT_MEM;
				end else begin
					arch_write(ins.rd, {v[31:8], arch_mem[addr[7:0]]});
				end
			end
			CMD_SB: begin
				if (!fits(addr, 1)) begin
					res.flt = FAULT_MEM;
				end else begin
					arch_mem[addr[7:0]] = v[7:0];
				end
			end
			CMD_LA: begin
				arch_write(ins.rd, ins.imm);
			end
			CMD_SYSCALL: begin
				code = arch_read(v0_sel);
				arg = arch_read(a0_sel);
				if (code == SYS_PRINT_INT) begin
					res.pv = 1'b1;
					res.pk = PRINT_INT;
					res.pval = arg;
				end else if (code == SYS_PRINT_CHAR) begin
					if (arg[7:0] != 8'd0) begin
						res.pv = 1'b1;
						res.pk = PRINT_CHAR;
						res.pval = {24'd0, arg[7:0]};
					end
				end else if (code == SYS_EXIT) begin
					arch_pc = prog_len;
					res.halt = 1'b1;
				end
			end
			default: begin
			end
			endcase
		end
		res.pc = arch_pc;
		n_prints += res.pv;
		n_halts += res.halt;
		n_mem_faults += (res.flt == FAULT_MEM);
		n_jump_faults += (res.flt == FAULT_JUMP);
	endtask

	task automatic push_instr(input instr_t ins, input bit typed, input result_t typed_res);
		int gap;
		result_t predicted;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= ins.op;
		dst_reg <= ins.rd;
		src_a_reg <= ins.ra;
		src_b_reg <= ins.rb;
		imm_value <= ins.imm;
		do @(posedge clk); while (in_ready !== 1'b1);
		run_instruction(ins, predicted);
		outcomes.push_back(typed ? typed_res : predicted);
		sent_count++;
	endtask

	// hold off until every outstanding transaction has retired
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outcomes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] jumps_cap, input logic [15:0] length,
			input logic [4:0] ra, input logic [4:0] sp, input logic [4:0] v0, input logic [4:0] a0);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_W-1:0] val [6];
		idx = '{CFG_MAX_JUMPS, CFG_PROGRAM_LENGTH, CFG_RA_INDEX, CFG_SP_INDEX,
			CFG_V0_INDEX, CFG_A0_INDEX};
		val = '{jumps_cap, length, {11'd0, ra}, {11'd0, sp}, {11'd0, v0}, {11'd0, a0}};
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cap_jumps = jumps_cap;
		prog_len = length;
		ra_sel = ra;
		sp_sel = sp;
		v0_sel = v0;
		a0_sel = a0;
	endtask

	task automatic issue_fragment();
		int n;
		logic [4:0] base;
		logic [4:0] ra;
		logic [31:0] code;
		case ($urandom_range(9, 0))
		0, 1, 2: begin
			push_instr(mk(($urandom_range(3, 0) == 0) ? CMD_LA : 5'($urandom_range(CMD_XOR, CMD_ADDI)),
				pick_reg(), pick_reg(), pick_reg(), rand_word()), 1'b0, '0);
		end
		3, 4: begin
			// base register pointed near memory, then a few accesses around it
			base = 5'($urandom_range(17, 0));
			push_instr(mk(CMD_LA, base, 5'd0, 5'd0,
				($urandom_range(7, 0) == 0) ? rand_word() : 32'($urandom_range(259, 0))), 1'b0, '0);
			n = $urandom_range(4, 1);
			repeat (n) begin
				push_instr(mk(5'($urandom_range(CMD_SB, CMD_LW)), pick_reg(), base, 5'd0,
					32'($urandom_range(8, 0)) - 32'd4), 1'b0, '0);
			end
		end
		5, 6: begin
			case ($urandom_range(4, 0))
			0: code = SYS_PRINT_INT;
			1: code = SYS_PRINT_CHAR;
			2: code = SYS_EXIT;
			3: code = 32'd4;
			default: code = $urandom_range(15, 0);
			endcase
			push_instr(mk(CMD_LA, v0_sel, 5'd0, 5'd0, code), 1'b0, '0);
			push_instr(mk(CMD_LA, a0_sel, 5'd0, 5'd0,
				$urandom_range(1, 0) ? rand_word() : ($urandom & 32'hFFFF_FF00)), 1'b0, '0);
			push_instr(mk(CMD_SYSCALL, pick_reg(), pick_reg(), pick_reg(), rand_word()), 1'b0, '0);
		end
		7, 8: begin
			ra = pick_reg();
			push_instr(mk(5'($urandom_range(CMD_JAL, CMD_BEQ)), pick_reg(), ra,
				($urandom_range(2, 0) == 0) ? ra : pick_reg(), rand_word()), 1'b0, '0);
		end
		default: begin
			push_instr(mk(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), $urandom),
				1'b0, '0);
		end
		endcase
	endtask

	initial begin : stimulus
		int start;
		logic [16:0] cap_sum;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= 5'd0;
		dst_reg <= 5'd0;
		src_a_reg <= 5'd0;
		src_b_reg <= 5'd0;
		imm_value <= 32'sd0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_MAX_JUMPS;
		cfg_data <= 16'd0;
		reset_arch();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i]) begin
			push_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].res);
		end
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			cap_sum = 17'(arch_jumps) + 17'((ph % 2) ? 400 : $urandom_range(60, 5));
			case (ph)
			0: begin
				write_settings(16'd0, 16'hFFFF, 5'd0, 5'd0, 5'd17, 5'd0);
			end
			1: begin
				write_settings(16'hFFFF, 16'd0, 5'd17, 5'd17, 5'd0, 5'd17);
			end
			default: begin
				write_settings(cap_sum[16] ? 16'hFFFF : cap_sum[15:0], 16'($urandom),
					5'($urandom_range(17, 0)), 5'($urandom_range(17, 0)),
					5'($urandom_range(17, 0)), 5'($urandom_range(17, 0)));
			end
			endcase
			start = sent_count;
			while (sent_count - start < PHASE_ITEMS) begin
				steady_run = ((sent_count / 64) % 4 == 0);
				issue_fragment();
				if ($urandom_range(60, 0) == 0) begin
					settle();
				end
			end
		end
		steady_run = 1'b0;
		settle();
		repeat (4) @(posedge clk);
		$display("%0d instructions retired over %0d register settings; %0d prints, %0d exits",
			retired_count, RANDOM_PHASES + 1, n_prints, n_halts);
		$display("memory faults %0d, jump limit faults %0d", n_mem_faults, n_jump_faults);
		if (mismatch_count == 0 && outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : retire_check
		int stall;
		result_t got;
		result_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = '{next_pc, fault, print_valid, print_kind, print_value, halted};
			retired_count++;
			if (outcomes.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected transaction: pc %h fault %0d", got.pc, got.flt);
				end
				mismatch_count++;
			end else begin
				want = outcomes.pop_front();
				if (got.pc !== want.pc || got.flt !== want.flt || got.pv !== want.pv ||
						got.pk !== want.pk || got.pval !== want.pval || got.halt !== want.halt) begin
					if (mismatch_count < 10) begin
						$display("mismatch on result %0d: want pc %h fault %0d print %b/%b/%h halt %b",
							retired_count, want.pc, want.flt, want.pv, want.pk, want.pval, want.halt);
						$display("                           got pc %h fault %0d print %b/%b/%h halt %b",
							got.pc, got.flt, got.pv, got.pk, got.pval, got.halt);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
